[hw/rtl/psel_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psel_pkg: power source selector shared definitions
// Word types, register codes and the time-of-day reduction used by the
// configuration registers and the peak window stage.
// ----------------------------------------------------------------------------
package psel_pkg;

  localparam int unsigned TIME_W = 17;
  localparam int unsigned LVL_W  = 4;
  localparam logic [TIME_W-1:0] DAY_SECONDS = 17'd86400;
  localparam logic [LVL_W-1:0]  LVL_FULL    = 4'd15;

  localparam logic [TIME_W-1:0] EVE_START_RST = 17'd61200;
  localparam logic [TIME_W-1:0] EVE_LEN_RST   = 17'd10800;
  localparam logic [TIME_W-1:0] MOR_START_RST = 17'd21600;
  localparam logic [TIME_W-1:0] MOR_LEN_RST   = 17'd10800;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_AC_LOSS = 2'd1,
    ACT_BUTTON  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_EVE_START = 2'd0,
    CFG_EVE_LEN   = 2'd1,
    CFG_MOR_START = 2'd2,
    CFG_MOR_LEN   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    action_t             action;
    logic [TIME_W-1:0]   time_of_day;
    logic [LVL_W-1:0]    battery_level;
    logic                ac_available;
    logic                solar_charging;
    logic                wind_charging;
  } in_word_t;

  typedef struct packed {
    logic ac_supply_on;
    logic dc_supply_on;
    logic sell_to_grid;
    logic manual_mode;
  } out_word_t;

  // start is kept already reduced to one day
  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] length;
  } window_t;

  typedef struct packed {
    window_t eve;
    window_t mor;
  } peak_cfg_t;

  typedef struct packed {
    in_word_t word;
    logic     peak;
  } peak_word_t;

  // values stay below twice a day, so one compare and subtract is enough
  function automatic logic [TIME_W-1:0] mod_day(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] r;
    r = (v >= DAY_SECONDS) ? (v - DAY_SECONDS) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/psel_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psel_cfg: peak window registers
// Holds the two peak windows; starts are stored reduced to one day.
// ----------------------------------------------------------------------------
module psel_cfg (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       wr_en,
  input  psel_pkg::cfg_reg_t        wr_index,
  input  wire [psel_pkg::TIME_W-1:0] wr_data,
  output psel_pkg::peak_cfg_t       peak_cfg
);
  import psel_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_cfg.eve.start  <= EVE_START_RST;
      peak_cfg.eve.length <= EVE_LEN_RST;
      peak_cfg.mor.start  <= MOR_START_RST;
      peak_cfg.mor.length <= MOR_LEN_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_EVE_START: peak_cfg.eve.start  <= mod_day(wr_data);
        CFG_EVE_LEN:   peak_cfg.eve.length <= wr_data;
        CFG_MOR_START: peak_cfg.mor.start  <= mod_day(wr_data);
        CFG_MOR_LEN:   peak_cfg.mor.length <= wr_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/psel_peak.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psel_peak: peak window stage
// Checks the word's time of day against both windows and registers the
// word together with the peak flag.
// ----------------------------------------------------------------------------
module psel_peak (
  input  wire                  clk,
  input  wire                  rst,
  input  psel_pkg::peak_cfg_t  peak_cfg,
  input  wire                  word_valid,
  input  psel_pkg::in_word_t   word,
  output logic                 word_ready,
  output logic                 pk_valid,
  output psel_pkg::peak_word_t pk_word,
  input  wire                  pk_ready
);
  import psel_pkg::*;

  logic [TIME_W-1:0] tt;
  logic [TIME_W:0]   eve_raw;
  logic [TIME_W:0]   mor_raw;
  logic [TIME_W-1:0] eve_diff;
  logic [TIME_W-1:0] mor_diff;
  logic              peak;

  assign tt      = mod_day(word.time_of_day);
  assign eve_raw = {1'b0, tt} - {1'b0, peak_cfg.eve.start};
  assign mor_raw = {1'b0, tt} - {1'b0, peak_cfg.mor.start};
  // a borrow means the window start lies later in the day: wrap by one day
  assign eve_diff = eve_raw[TIME_W] ? (eve_raw[TIME_W-1:0] + DAY_SECONDS)
                                    : eve_raw[TIME_W-1:0];
  assign mor_diff = mor_raw[TIME_W] ? (mor_raw[TIME_W-1:0] + DAY_SECONDS)
                                    : mor_raw[TIME_W-1:0];
  assign peak = (eve_diff < peak_cfg.eve.length) || (mor_diff < peak_cfg.mor.length);

  assign word_ready = !pk_valid || pk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_valid <= 1'b0;
    end else if (word_ready) begin
      pk_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      pk_word.word <= word;
      pk_word.peak <= peak;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/psel_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psel_core: source selection state and result register
// Applies tick, ac loss and button words to the selection state and
// registers the resulting state as the output word.
// ----------------------------------------------------------------------------
module psel_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  pk_valid,
  input  psel_pkg::peak_word_t pk_word,
  output logic                 pk_ready,
  output logic                 out_valid,
  output psel_pkg::out_word_t  out_data,
  input  wire                  out_ready
);
  import psel_pkg::*;

  logic ac_sel, dc_sel, manual, selling;
  logic ac_sel_next, dc_sel_next, manual_next, selling_next;
  logic b0, b1, b2, b3, charging, low3_charging, depleted, below, peak, ac_av;
  logic take;

  assign b0            = pk_word.word.battery_level[0];
  assign b1            = pk_word.word.battery_level[1];
  assign b2            = pk_word.word.battery_level[2];
  assign b3            = pk_word.word.battery_level[3];
  assign ac_av         = pk_word.word.ac_available;
  assign peak          = pk_word.peak;
  assign charging      = pk_word.word.solar_charging || pk_word.word.wind_charging;
  assign low3_charging = charging && b2 && b1 && b0;
  assign depleted      = !b3 && !low3_charging;
  assign below         = (!b1 && !b0) || !b2;

  assign pk_ready = !out_valid || out_ready;
  assign take     = pk_valid && pk_ready;

  always_comb begin
    ac_sel_next  = ac_sel;
    dc_sel_next  = dc_sel;
    manual_next  = manual;
    selling_next = selling;
    case (pk_word.word.action)
      ACT_TICK: begin
        // nothing selected yet: start from ac when present
        if (!ac_sel && !dc_sel) begin
          ac_sel_next = ac_av;
          dc_sel_next = !ac_av;
        end
        if (ac_sel_next) begin
          dc_sel_next  = 1'b0;
          selling_next = 1'b0;
          if (!manual &&
              ((pk_word.word.battery_level == LVL_FULL) || (peak && (b3 || low3_charging)))) begin
            dc_sel_next = 1'b1;
            ac_sel_next = 1'b0;
          end
        end else begin
          if (!manual && ac_av && (depleted || (!peak && below))) begin
            ac_sel_next = 1'b1;
            dc_sel_next = 1'b0;
          end
          selling_next = ac_av && charging && b3 && b2 && b1;
        end
      end
      ACT_AC_LOSS: begin
        dc_sel_next = 1'b1;
        ac_sel_next = 1'b0;
      end
      ACT_BUTTON: begin
        if (!manual) begin
          ac_sel_next = dc_sel;
          dc_sel_next = !dc_sel;
        end
        manual_next = !manual;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ac_sel    <= 1'b0;
      dc_sel    <= 1'b0;
      manual    <= 1'b0;
      selling   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        ac_sel    <= ac_sel_next;
        dc_sel    <= dc_sel_next;
        manual    <= manual_next;
        selling   <= selling_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.ac_supply_on <= ac_sel_next;
      out_data.dc_supply_on <= dc_sel_next;
      out_data.sell_to_grid <= selling_next;
      out_data.manual_mode  <= manual_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/power_source_selector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// power_source_selector: ac grid / battery supply selection
// Picks the house supply, tracks manual mode and decides grid selling.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    in_data   (in_word_t)
//  out      out_valid/out_ready  out_data  (out_word_t)
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one word per cycle sustained while the output is not stalled; three register
//  stages (input, peak window, state/result), which each word passes in turn
//  the selection state is read and written once per taken word in the last stage
//  reset clears all stage valids, the state and the peak windows to defaults
//  a stall at the output backs up stage by stage; each stage refills as
//  soon as the one after it moves, cfg_ready is always high
// ----------------------------------------------------------------------------
module power_source_selector (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  psel_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output psel_pkg::out_word_t        out_data,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  psel_pkg::cfg_reg_t         cfg_index,
  input  wire [psel_pkg::TIME_W-1:0] cfg_data
);
  import psel_pkg::*;

  logic       s1_valid;
  in_word_t   s1_word;
  logic       s1_ready;
  peak_cfg_t  peak_cfg;
  logic       pk_valid;
  logic       pk_ready;
  peak_word_t pk_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_data;
    end
  end

  psel_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .peak_cfg (peak_cfg)
  );

  psel_peak u_peak (
    .clk        (clk),
    .rst        (rst),
    .peak_cfg   (peak_cfg),
    .word_valid (s1_valid),
    .word       (s1_word),
    .word_ready (s1_ready),
    .pk_valid   (pk_valid),
    .pk_word    (pk_word),
    .pk_ready   (pk_ready)
  );

  psel_core u_core (
    .clk       (clk),
    .rst       (rst),
    .pk_valid  (pk_valid),
    .pk_word   (pk_word),
    .pk_ready  (pk_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

[hw/rtl/psel_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psel_checker: port level checks for power_source_selector
// Watches the output and configuration ports over time.
// ----------------------------------------------------------------------------
module psel_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 out_valid,
  input wire                 out_ready,
  input psel_pkg::out_word_t out_data,
  input wire                 cfg_ready
);
  import psel_pkg::*;

  // both supplies are never switched on together
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.ac_supply_on && out_data.dc_supply_on))
    else $error("ac and dc supply both on");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // output empty, in_valid low now and in past samples: no result next cycle
  a_no_word_no_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_valid && !$past(in_valid) && !$past(in_valid, 2) && !$past(rst)
      && !$past(rst, 2) |=> !out_valid || $past(in_valid, 2))
    else $error("result without a word");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind power_source_selector psel_checker u_psel_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: power source selector testbench
// Drives event words (ticks, ac-loss events, button presses and undefined
// actions) through the valid/ready input, predicts every result word in a
// behavioral copy of the supply selection rules and peak windows, and checks
// each result field by field. A directed table comes first, then random
// traffic under several peak window settings, with bursty input, a stalling
// receiver and long output hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  import psel_pkg::*;

  localparam int unsigned DAY            = DAY_SECONDS;
  localparam int unsigned N_DIRECTED     = 23;
  localparam int unsigned N_PHASES       = 6;
  localparam int unsigned RAND_PER_PHASE = 170;
  localparam int unsigned LONG_HOLD      = 120;
  localparam int unsigned HOLD_AT_A      = 270;
  localparam int unsigned HOLD_AT_B      = 620;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned LIMIT          = 400000;
  localparam action_t     ACT_UNDEF      = action_t'(2'd3);

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_word_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = CFG_EVE_START;
  logic [TIME_W-1:0]   cfg_data  = '0;

  // predictor state
  logic [TIME_W-1:0] peak_reg [4] = '{EVE_START_RST, EVE_LEN_RST, MOR_START_RST, MOR_LEN_RST};
  bit on_ac, on_dc, manual, selling;

  out_word_t   supply_q [$];
  stim_row_t   directed [N_DIRECTED];
  int unsigned words_out  = 0;
  int unsigned errors     = 0;
  int unsigned burst_left = 1;

  always #1 clk = ~clk;

  power_source_selector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic bit falls_in_window(input int unsigned t, input int unsigned start,
                                         input int unsigned len);
    int unsigned d;
    d = (t % DAY + DAY - start % DAY) % DAY;
    return d < len;
  endfunction

  function automatic out_word_t next_supply(input in_word_t w);
    logic [LVL_W-1:0] lvl;
    bit charging, low3, peak, depleted, below;
    out_word_t r;
    lvl      = w.battery_level;
    charging = w.solar_charging || w.wind_charging;
    low3     = charging && (lvl[2:0] == 3'b111);
    peak     = falls_in_window(w.time_of_day, peak_reg[CFG_EVE_START], peak_reg[CFG_EVE_LEN]) ||
               falls_in_window(w.time_of_day, peak_reg[CFG_MOR_START], peak_reg[CFG_MOR_LEN]);
    case (w.action)
      ACT_TICK: begin
        // nothing selected yet: start on ac if present
        if (!on_ac && !on_dc) begin
          on_ac = w.ac_available;
          on_dc = !w.ac_available;
        end
        if (on_ac) begin
          on_dc   = 1'b0;
          selling = 1'b0;
          if (!manual && (lvl == LVL_FULL || (peak && (lvl[3] || low3)))) begin
            on_dc = 1'b1;
            on_ac = 1'b0;
          end
        end else begin
          if (!manual && w.ac_available) begin
            depleted = !lvl[3] && !low3;
            below    = (lvl[1:0] == 2'b00) || !lvl[2];
            if (depleted || (!peak && below)) begin
              on_ac = 1'b1;
              on_dc = 1'b0;
            end
          end
          // decided even when this tick went back to ac
          selling = w.ac_available && charging && (lvl[3:1] == 3'b111);
        end
      end
      ACT_AC_LOSS: begin
        on_dc = 1'b1;
        on_ac = 1'b0;
      end
      ACT_BUTTON: begin
        if (!manual) begin
          on_ac = on_dc;
          on_dc = !on_ac;
        end
        manual = !manual;
      end
      default: ;
    endcase
    r.ac_supply_on = on_ac;
    r.dc_supply_on = on_dc;
    r.sell_to_grid = selling;
    r.manual_mode  = manual;
    return r;
  endfunction

  function automatic stim_row_t stim(input action_t a, input int unsigned t, input int unsigned lvl,
                                     input bit ac, input bit sol, input bit wnd,
                                     input bit typed, input out_word_t want);
    stim_row_t s;
    s.w.action         = a;
    s.w.time_of_day    = t[TIME_W-1:0];
    s.w.battery_level  = lvl[LVL_W-1:0];
    s.w.ac_available   = ac;
    s.w.solar_charging = sol;
    s.w.wind_charging  = wnd;
    s.typed            = typed;
    s.want             = want;
    return s;
  endfunction

  function automatic in_word_t draw_event();
    in_word_t w;
    int unsigned r, s, len;
    int base, off;
    r = $urandom_range(0, 99);
    if (r < 72)      w.action = ACT_TICK;
    else if (r < 82) w.action = ACT_AC_LOSS;
    else if (r < 97) w.action = ACT_BUTTON;
    else             w.action = ACT_UNDEF;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      w.time_of_day = TIME_W'($urandom_range(DAY, 2 ** TIME_W - 1));
    end else if (r < 30) begin
      // land on or next to a window edge
      if ($urandom_range(0, 1) == 1) begin
        s   = peak_reg[CFG_EVE_START];
        len = peak_reg[CFG_EVE_LEN];
      end else begin
        s   = peak_reg[CFG_MOR_START];
        len = peak_reg[CFG_MOR_LEN];
      end
      case ($urandom_range(0, 3))
        0:       off = 0;
        1:       off = -1;
        2:       off = int'(len) - 1;
        default: off = int'(len);
      endcase
      base          = int'(s % DAY) + off;
      w.time_of_day = TIME_W'(((base % int'(DAY)) + int'(DAY)) % int'(DAY));
    end else begin
      w.time_of_day = TIME_W'($urandom_range(0, DAY - 1));
    end
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 4))
        0:       w.battery_level = 4'd0;
        1:       w.battery_level = 4'd7;
        2:       w.battery_level = 4'd8;
        3:       w.battery_level = 4'd14;
        default: w.battery_level = LVL_FULL;
      endcase
    end else begin
      w.battery_level = LVL_W'($urandom_range(0, 15));
    end
    w.ac_available   = ($urandom_range(0, 4) != 0);
    w.solar_charging = 1'($urandom_range(0, 1));
    w.wind_charging  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t pred;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = next_supply(w);
    supply_q.push_back(typed ? want : pred);
    gap = 0;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender goes quiet until every result is back
  task automatic pause_sender();
    in_valid <= 1'b0;
    while (supply_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : check_result
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (supply_q.size() == 0) begin
        $error("result word with nothing expected: %b", out_data);
        errors++;
      end else begin
        want = supply_q.pop_front();
        if (out_data.ac_supply_on !== want.ac_supply_on) begin
          $error("ac_supply_on: expected %0b, got %0b", want.ac_supply_on, out_data.ac_supply_on);
          errors++;
        end
        if (out_data.dc_supply_on !== want.dc_supply_on) begin
          $error("dc_supply_on: expected %0b, got %0b", want.dc_supply_on, out_data.dc_supply_on);
          errors++;
        end
        if (out_data.sell_to_grid !== want.sell_to_grid) begin
          $error("sell_to_grid: expected %0b, got %0b", want.sell_to_grid, out_data.sell_to_grid);
          errors++;
        end
        if (out_data.manual_mode !== want.manual_mode) begin
          $error("manual_mode: expected %0b, got %0b", want.manual_mode, out_data.manual_mode);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, plus two long hold-offs so the pipe backs up into in_ready
  initial begin : result_sink
    int unsigned mode_left;
    int unsigned pct;
    int unsigned holds_done;
    mode_left  = 0;
    pct        = 100;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if ((holds_done == 0 && words_out >= HOLD_AT_A) ||
          (holds_done == 1 && words_out >= HOLD_AT_B)) begin
        out_ready <= 1'b0;
        holds_done++;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(5, 60);
          case ($urandom_range(0, 2))
            0:       pct = 100;
            1:       pct = 60;
            default: pct = 25;
          endcase
        end
        mode_left--;
        out_ready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main
    logic [3:0][TIME_W-1:0] regs;
    // expected columns: ac, dc, sell, manual
    directed = '{
      stim(ACT_UNDEF,   0,      0,  0, 0, 0, 1, 4'b0000),  // undefined action out of reset
      stim(ACT_TICK,    0,      0,  1, 0, 0, 1, 4'b1000),  // first tick picks ac
      stim(ACT_TICK,    0,      15, 1, 0, 0, 1, 4'b0100),  // full battery
      stim(ACT_TICK,    0,      15, 1, 1, 0, 0, '0),
      stim(ACT_AC_LOSS, 0,      0,  0, 0, 0, 0, '0),
      stim(ACT_TICK,    0,      0,  1, 0, 0, 0, '0),       // depleted, back to ac
      stim(ACT_TICK,    86399,  8,  1, 0, 0, 1, 4'b1000),  // last second of the day
      stim(ACT_TICK,    61200,  8,  1, 0, 0, 0, '0),       // evening window opens
      stim(ACT_TICK,    71999,  8,  1, 0, 0, 0, '0),
      stim(ACT_TICK,    72000,  8,  1, 0, 0, 0, '0),       // just past evening window
      stim(ACT_TICK,    21600,  7,  1, 0, 1, 0, '0),       // morning window, charging
      stim(ACT_TICK,    32400,  7,  0, 0, 1, 0, '0),
      stim(ACT_BUTTON,  0,      0,  0, 0, 0, 0, '0),
      stim(ACT_TICK,    0,      15, 1, 0, 0, 0, '0),       // manual holds the source
      stim(ACT_BUTTON,  0,      0,  0, 0, 0, 0, '0),
      stim(ACT_BUTTON,  0,      0,  0, 0, 0, 0, '0),
      stim(ACT_TICK,    0,      14, 1, 1, 0, 0, '0),       // selling while manual
      stim(ACT_BUTTON,  0,      0,  0, 0, 0, 0, '0),
      stim(ACT_TICK,    131071, 0,  0, 0, 0, 1, 4'b0100),  // time past one day
      stim(ACT_UNDEF,   131071, 15, 1, 1, 1, 1, 4'b0100),
      stim(ACT_TICK,    0,      0,  1, 0, 0, 0, '0),
      stim(ACT_AC_LOSS, 0,      0,  1, 0, 0, 0, '0),
      stim(ACT_TICK,    43200,  15, 1, 1, 1, 0, '0)
    };
    on_ac   = 1'b0;
    on_dc   = 1'b0;
    manual  = 1'b0;
    selling = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      pause_sender();
      case (p)
        0: begin
          regs[CFG_EVE_START] = TIME_W'($urandom_range(0, DAY - 1));
          regs[CFG_EVE_LEN]   = TIME_W'($urandom_range(0, DAY));
          regs[CFG_MOR_START] = TIME_W'($urandom_range(0, DAY - 1));
          regs[CFG_MOR_LEN]   = TIME_W'($urandom_range(0, DAY));
        end
        1: begin
          // empty evening window, morning covers the day
          regs[CFG_EVE_START] = '0;
          regs[CFG_EVE_LEN]   = '0;
          regs[CFG_MOR_START] = TIME_W'(DAY - 1);
          regs[CFG_MOR_LEN]   = TIME_W'(DAY);
        end
        2: begin
          regs[CFG_EVE_START] = '1;
          regs[CFG_EVE_LEN]   = '1;
          regs[CFG_MOR_START] = '0;
          regs[CFG_MOR_LEN]   = TIME_W'(1);
        end
        3: begin
          regs[CFG_EVE_START] = TIME_W'($urandom_range(0, DAY - 1));
          regs[CFG_EVE_LEN]   = TIME_W'($urandom_range(1, 3600));
          regs[CFG_MOR_START] = TIME_W'($urandom_range(0, DAY - 1));
          regs[CFG_MOR_LEN]   = TIME_W'($urandom_range(1, 3600));
        end
        4: begin
          // window wrapping over midnight
          regs[CFG_EVE_START] = TIME_W'(DAY - 1);
          regs[CFG_EVE_LEN]   = TIME_W'(2);
          regs[CFG_MOR_START] = '0;
          regs[CFG_MOR_LEN]   = TIME_W'(DAY - 1);
        end
        default: begin
          regs[CFG_EVE_START] = EVE_START_RST;
          regs[CFG_EVE_LEN]   = EVE_LEN_RST;
          regs[CFG_MOR_START] = MOR_START_RST;
          regs[CFG_MOR_LEN]   = MOR_LEN_RST;
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_reg_t'(i);
        cfg_data  <= regs[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        peak_reg[i] = regs[i];
      end
      cfg_valid <= 1'b0;
      repeat (RAND_PER_PHASE) send_word(draw_event(), 1'b0, '0);
    end

    pause_sender();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (supply_q.size() != 0) begin
      $error("%0d result words never arrived", supply_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
